// ----- rtl/k_way_merge_sorted_blocks_defines.svh -----
// Assertion macros shared by the k-way merge RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef K_WAY_MERGE_SORTED_BLOCKS_DEFINES_SVH
`define K_WAY_MERGE_SORTED_BLOCKS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KWM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/kwm_pkg.sv -----
// Shared types and constants for the k-way merge block.
// No dependencies.
package kwm_pkg;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_PULL  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [3:0] NUM_BLOCKS_RESET = 4'd8;

	typedef struct packed {
		logic signed [31:0] merged_value;
		logic [2:0]         source_block;
		logic               is_last;
		logic               was_empty;
		logic               overflowed;
	} kwm_result_t;

endpackage

// ----- rtl/kwm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/kwm_seq.sv -----
// Request sequencer for the k-way merge: loads, pull scan over block heads, clear.
// Depends on kwm_pkg; drives the pointer RAM and the element RAM instanced above it.
module kwm_seq #(
	parameter int MAX_BLOCKS  = 8,
	parameter int BLOCK_DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic [1:0]                                req_type,
	input  logic [2:0]                                block_index,
	input  logic [31:0]                               load_value,
	input  logic [$clog2(MAX_BLOCKS+1)-1:0]           n_act,
	output logic                                      busy,
	output logic                                      res_valid,
	output kwm_pkg::kwm_result_t                      res,
	output logic                                      ptr_we,
	output logic [$clog2(MAX_BLOCKS)-1:0]             ptr_waddr,
	output logic [2*$clog2(BLOCK_DEPTH+1)-1:0]        ptr_wdata,
	output logic                                      ptr_re,
	output logic [$clog2(MAX_BLOCKS)-1:0]             ptr_raddr,
	input  logic [2*$clog2(BLOCK_DEPTH+1)-1:0]        ptr_rdata,
	output logic                                      el_we,
	output logic [$clog2(MAX_BLOCKS)+$clog2(BLOCK_DEPTH)-1:0] el_waddr,
	output logic [31:0]                               el_wdata,
	output logic                                      el_re,
	output logic [$clog2(MAX_BLOCKS)+$clog2(BLOCK_DEPTH)-1:0] el_raddr,
	input  logic [31:0]                               el_rdata
);

	localparam int BW = $clog2(MAX_BLOCKS);
	localparam int IW = $clog2(BLOCK_DEPTH);
	localparam int LW = $clog2(BLOCK_DEPTH + 1);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int SW = $clog2(MAX_BLOCKS * BLOCK_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LD   = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]               state_q;
	logic [MAX_BLOCKS-1:0]    valid_q;
	logic                     ovf_q;
	logic [CW-1:0]            pi_q;
	logic                     vld_s1;
	logic                     vld_s2;
	logic                     found_q;
	logic                     res_valid_q;

	logic [BW-1:0]            blk_q;
	logic [31:0]              val_q;
	logic [BW-1:0]            blk_s1;
	logic [BW-1:0]            blk_s2;
	logic                     has_s2;
	logic [LW-1:0]            len_s2;
	logic [LW-1:0]            head_s2;
	logic [BW-1:0]            best_blk_q;
	logic signed [31:0]       best_val_q;
	logic [LW-1:0]            best_len_q;
	logic [LW-1:0]            best_head_q;
	logic [SW-1:0]            sum_q;
	kwm_pkg::kwm_result_t     res_q;

	logic                     accept;
	logic                     blk_ok;
	logic [BW-1:0]            rd_blk;
	logic [LW-1:0]            cur_len;
	logic [LW-1:0]            cur_head;
	logic                     cur_has;
	logic                     room;
	logic                     issue;
	logic                     take;

	assign accept = start && (state_q == ST_IDLE);
	assign blk_ok = int'(block_index) < MAX_BLOCKS;
	assign busy = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	// A block without its valid bit reads as empty.
	always_comb begin
		rd_blk = (state_q == ST_LD) ? blk_q : blk_s1;
		cur_len = valid_q[rd_blk] ? ptr_rdata[2*LW-1:LW] : '0;
		cur_head = valid_q[rd_blk] ? ptr_rdata[LW-1:0] : '0;
		cur_has = cur_head < cur_len;
		room = cur_len < LW'(BLOCK_DEPTH);
		issue = (state_q == ST_SCAN) && (pi_q < n_act);
		take = vld_s2 && has_s2 && (!found_q || ($signed(el_rdata) <= best_val_q));
	end

	always_comb begin
		ptr_re = (accept && (req_type == kwm_pkg::REQ_LOAD) && blk_ok) || issue;
		ptr_raddr = (state_q == ST_IDLE) ? BW'(block_index) : BW'(pi_q);
		ptr_we = ((state_q == ST_LD) && room) || ((state_q == ST_DONE) && found_q);
		ptr_waddr = (state_q == ST_LD) ? blk_q : best_blk_q;
		ptr_wdata = (state_q == ST_LD) ? {LW'(cur_len + 1'b1), cur_head}
			: {best_len_q, LW'(best_head_q + 1'b1)};
		el_we = (state_q == ST_LD) && room;
		el_waddr = {blk_q, IW'(cur_len)};
		el_wdata = val_q;
		el_re = (state_q == ST_SCAN) && vld_s1 && cur_has;
		el_raddr = {blk_s1, IW'(cur_head)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			ovf_q <= 1'b0;
			pi_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			found_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			vld_s1 <= issue;
			vld_s2 <= vld_s1 && (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							kwm_pkg::REQ_LOAD: begin
								if (blk_ok) begin
									state_q <= ST_LD;
								end
							end
							kwm_pkg::REQ_PULL: begin
								state_q <= ST_SCAN;
								pi_q <= '0;
								found_q <= 1'b0;
							end
							kwm_pkg::REQ_CLEAR: begin
								valid_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LD: begin
					if (room) begin
						valid_q[blk_q] <= 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (issue) begin
						pi_q <= CW'(pi_q + 1'b1);
					end
					if (take) begin
						found_q <= 1'b1;
					end
					// Drained once all heads are issued and both stages are empty.
					if (!issue && !vld_s1 && !vld_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					res_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q <= BW'(block_index);
			val_q <= load_value;
			sum_q <= '0;
		end
		blk_s1 <= BW'(pi_q);
		blk_s2 <= blk_s1;
		has_s2 <= cur_has;
		len_s2 <= cur_len;
		head_s2 <= cur_head;
		if ((state_q == ST_SCAN) && vld_s1) begin
			sum_q <= SW'(sum_q + SW'(cur_len - cur_head));
		end
		// Ties go to the later block: keep the newest head that is not larger.
		if ((state_q == ST_SCAN) && take) begin
			best_blk_q <= blk_s2;
			best_val_q <= $signed(el_rdata);
			best_len_q <= len_s2;
			best_head_q <= head_s2;
		end
		if (state_q == ST_DONE) begin
			res_q.overflowed <= ovf_q;
			if (found_q) begin
				res_q.merged_value <= best_val_q;
				res_q.source_block <= 3'(best_blk_q);
				res_q.is_last <= (sum_q == SW'(1));
				res_q.was_empty <= 1'b0;
			end else begin
				res_q.merged_value <= '0;
				res_q.source_block <= '0;
				res_q.is_last <= 1'b0;
				res_q.was_empty <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/k_way_merge_sorted_blocks.sv -----
// Top level of the k-way merge over sorted blocks: config register, RAMs, sequencer.
// Depends on kwm_pkg, kwm_ram, kwm_seq and k_way_merge_sorted_blocks_defines.svh.
//
// Usage: an item is taken when start is high and busy is low. A load appends
// load_value to block block_index and raises busy while it writes, so the next
// item waits for that write; a clear empties every block and leaves busy low.
// A pull scans the heads of the n active blocks (num_blocks, with 0 read as 1
// and values above MAX_BLOCKS capped) and holds busy through one pointer-RAM
// read per block, one element-RAM read and one compare per block, pipelined
// behind those reads, a drain step, and a write-back of the consumed head.
// Each pull yields one word on the result ports in the first cycle with busy
// low, marked by result_valid for exactly one cycle; the receiver cannot stall,
// so the word must be captured then. A new item may be started in that same
// cycle. num_blocks is written through the cfg_valid/cfg_ready channel, which
// is ready only while the block is idle.
`include "k_way_merge_sorted_blocks_defines.svh"

module k_way_merge_sorted_blocks #(
	parameter int MAX_BLOCKS  = 8,
	parameter int BLOCK_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [2:0]         block_index,
	input  logic signed [31:0] load_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         num_blocks,
	output logic               result_valid,
	output logic signed [31:0] merged_value,
	output logic [2:0]         source_block,
	output logic               is_last,
	output logic               was_empty,
	output logic               overflowed
);

	localparam int BW = $clog2(MAX_BLOCKS);
	localparam int IW = $clog2(BLOCK_DEPTH);
	localparam int LW = $clog2(BLOCK_DEPTH + 1);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	logic [3:0]              num_q;
	logic [CW-1:0]           n_act;
	kwm_pkg::kwm_result_t    res;

	logic                    ptr_we;
	logic [BW-1:0]           ptr_waddr;
	logic [2*LW-1:0]         ptr_wdata;
	logic                    ptr_re;
	logic [BW-1:0]           ptr_raddr;
	logic [2*LW-1:0]         ptr_rdata;
	logic                    el_we;
	logic [BW+IW-1:0]        el_waddr;
	logic [31:0]             el_wdata;
	logic                    el_re;
	logic [BW+IW-1:0]        el_raddr;
	logic [31:0]             el_rdata;

	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= kwm_pkg::NUM_BLOCKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			num_q <= num_blocks;
		end
	end

	// Clamp the block count into 1 .. MAX_BLOCKS.
	always_comb begin
		if (num_q == '0) begin
			n_act = CW'(1);
		end else if (int'(num_q) > MAX_BLOCKS) begin
			n_act = CW'(MAX_BLOCKS);
		end else begin
			n_act = CW'(num_q);
		end
	end

	kwm_ram #(
		.WIDTH(2 * LW),
		.DEPTH(MAX_BLOCKS)
	) u_ptr_ram (
		.clk  (clk),
		.we   (ptr_we),
		.waddr(ptr_waddr),
		.wdata(ptr_wdata),
		.re   (ptr_re),
		.raddr(ptr_raddr),
		.rdata(ptr_rdata)
	);

	kwm_ram #(
		.WIDTH(32),
		.DEPTH(MAX_BLOCKS * (2 ** IW))
	) u_el_ram (
		.clk  (clk),
		.we   (el_we),
		.waddr(el_waddr),
		.wdata(el_wdata),
		.re   (el_re),
		.raddr(el_raddr),
		.rdata(el_rdata)
	);

	kwm_seq #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.BLOCK_DEPTH(BLOCK_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.block_index(block_index),
		.load_value (load_value),
		.n_act      (n_act),
		.busy       (busy),
		.res_valid  (result_valid),
		.res        (res),
		.ptr_we     (ptr_we),
		.ptr_waddr  (ptr_waddr),
		.ptr_wdata  (ptr_wdata),
		.ptr_re     (ptr_re),
		.ptr_raddr  (ptr_raddr),
		.ptr_rdata  (ptr_rdata),
		.el_we      (el_we),
		.el_waddr   (el_waddr),
		.el_wdata   (el_wdata),
		.el_re      (el_re),
		.el_raddr   (el_raddr),
		.el_rdata   (el_rdata)
	);

	assign merged_value = res.merged_value;
	assign source_block = res.source_block;
	assign is_last = res.is_last;
	assign was_empty = res.was_empty;
	assign overflowed = res.overflowed;

	`KWM_ASSERT_IMPL(a_empty_word_zero, clk, arst_n, result_valid && was_empty, merged_value == 32'sd0 && source_block == 3'd0 && !is_last, "empty pull word must be all zero")
	`KWM_ASSERT_NEXT(a_pull_goes_busy, clk, arst_n, start && !busy && req_type == kwm_pkg::REQ_PULL, busy, "accepted pull must start the scan")
	`KWM_ASSERT_IMPL(a_word_after_scan, clk, arst_n, result_valid, $past(busy), "result word without a preceding scan")

endmodule

// ----- bench/tb_k_way_merge_sorted_blocks.sv -----
`timescale 1ns / 100ps
// Self-checking bench for k_way_merge_sorted_blocks: drives request and config words,
// predicts each pull with a behavioral merge and checks every result word field by field.
// Depends on kwm_pkg and the k_way_merge_sorted_blocks RTL.
module tb_k_way_merge_sorted_blocks;

	localparam int MAX_BLOCKS    = 8;
	localparam int BLOCK_DEPTH   = 256;
	localparam int ITEM_TARGET   = 1900;
	localparam int PHASE_ITEMS   = 120;
	localparam int SETTLE_CYCLES = 16;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	typedef struct {
		bit                 is_cfg;
		logic [1:0]         req;
		logic [2:0]         blk;
		logic signed [31:0] val;
		logic [3:0]         nb;
	} merge_word_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic [1:0]         req_type     = kwm_pkg::REQ_LOAD;
	logic [2:0]         block_index  = '0;
	logic signed [31:0] load_value   = '0;
	logic               cfg_valid    = 1'b0;
	logic [3:0]         num_blocks   = kwm_pkg::NUM_BLOCKS_RESET;
	logic               busy;
	logic               cfg_ready;
	logic               result_valid;
	logic signed [31:0] merged_value;
	logic [2:0]         source_block;
	logic               is_last;
	logic               was_empty;
	logic               overflowed;

	k_way_merge_sorted_blocks #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.BLOCK_DEPTH(BLOCK_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.block_index (block_index),
		.load_value  (load_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.num_blocks  (num_blocks),
		.result_valid(result_valid),
		.merged_value(merged_value),
		.source_block(source_block),
		.is_last     (is_last),
		.was_empty   (was_empty),
		.overflowed  (overflowed)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Behavioral copy of the merge state
	logic signed [31:0] blk_data [MAX_BLOCKS][BLOCK_DEPTH];
	int                 blk_len  [MAX_BLOCKS];
	int                 blk_head [MAX_BLOCKS];
	bit                 ovf_seen;
	logic [3:0]         nb_reg = kwm_pkg::NUM_BLOCKS_RESET;

	merge_word_t          pending_reqs [$];
	kwm_pkg::kwm_result_t merge_results_due [$];
	int                   items_made;
	int                   err_cnt;
	int                   taken_cnt;
	int                   cfg_cnt;
	int                   seen_taken;
	int                   seen_cfg;
	int                   gap_left;
	int                   settle_left;
	bit                   calm;

	task automatic merge_predict(input logic [1:0] req, input logic [2:0] blk,
			input logic signed [31:0] val);
		int                   n;
		int                   best;
		int                   remaining;
		bit                   found;
		logic signed [31:0]   best_val;
		kwm_pkg::kwm_result_t r;
		case (req)
		kwm_pkg::REQ_LOAD: begin
			if (blk_len[blk] < BLOCK_DEPTH) begin
				blk_data[blk][blk_len[blk]] = val;
				blk_len[blk]++;
			end else begin
				ovf_seen = 1'b1;
			end
		end
		kwm_pkg::REQ_CLEAR: begin
			// overflow stays sticky across a clear
			for (int b = 0; b < MAX_BLOCKS; b++) begin
				blk_len[b]  = 0;
				blk_head[b] = 0;
			end
		end
		kwm_pkg::REQ_PULL: begin
			n = (nb_reg == 0) ? 1 : (nb_reg > MAX_BLOCKS) ? MAX_BLOCKS : int'(nb_reg);
			found     = 1'b0;
			best      = 0;
			best_val  = '0;
			remaining = 0;
			// take equal heads too, so the highest block wins a tie
			for (int b = 0; b < n; b++) begin
				if (blk_head[b] < blk_len[b]) begin
					if (!found || blk_data[b][blk_head[b]] <= best_val) begin
						found    = 1'b1;
						best     = b;
						best_val = blk_data[b][blk_head[b]];
					end
				end
			end
			r = '0;
			r.overflowed = ovf_seen;
			if (!found) begin
				r.was_empty = 1'b1;
			end else begin
				blk_head[best]++;
				for (int b = 0; b < n; b++)
					remaining += blk_len[b] - blk_head[b];
				r.merged_value = best_val;
				r.source_block = best[2:0];
				r.is_last      = (remaining == 0);
			end
			merge_results_due.insert(merge_results_due.size(), r);
		end
		default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// Sample at the rising edge: results first, then the word taken in this cycle
	always @(posedge clk) begin
		kwm_pkg::kwm_result_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (merge_results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none got value %0h block %0d",
						$time, merged_value, source_block);
					err_cnt++;
				end else begin
					want = merge_results_due.pop_front();
					check_field("merged_value", want.merged_value, merged_value);
					check_field("source_block", want.source_block, source_block);
					check_field("is_last", want.is_last, is_last);
					check_field("was_empty", want.was_empty, was_empty);
					check_field("overflowed", want.overflowed, overflowed);
				end
			end
			if (start && !busy) begin
				merge_predict(req_type, block_index, load_value);
				taken_cnt++;
			end
			if (cfg_valid && cfg_ready) begin
				nb_reg = num_blocks;
				cfg_cnt++;
			end
		end
	end

	// Drive at the falling edge; a config write waits for an idle, drained block
	always @(negedge clk) begin
		merge_word_t nx;
		logic        d_start;
		logic        d_cfg;
		if (arst_n) begin
			d_start = start;
			d_cfg   = cfg_valid;
			if (start && taken_cnt != seen_taken) begin
				seen_taken  = taken_cnt;
				d_start     = 1'b0;
				gap_left    = calm ? 0 : $urandom_range(0, 10);
				settle_left = SETTLE_CYCLES;
				if ($urandom_range(0, 63) == 0)
					calm = !calm;
			end
			if (cfg_valid && cfg_cnt != seen_cfg) begin
				seen_cfg = cfg_cnt;
				d_cfg    = 1'b0;
			end
			if (!d_start && !d_cfg && pending_reqs.size() != 0) begin
				if (pending_reqs[0].is_cfg) begin
					if (merge_results_due.size() != 0) begin
						settle_left = SETTLE_CYCLES;
					end else if (settle_left != 0) begin
						settle_left--;
					end else begin
						nx         = pending_reqs.pop_front();
						d_cfg      = 1'b1;
						num_blocks <= nx.nb;
					end
				end else if (gap_left != 0) begin
					gap_left--;
				end else begin
					nx          = pending_reqs.pop_front();
					d_start     = 1'b1;
					req_type    <= nx.req;
					block_index <= nx.blk;
					load_value  <= nx.val;
				end
			end
			start     <= d_start;
			cfg_valid <= d_cfg;
		end
	end

	task automatic queue_req(input logic [1:0] req, input logic [2:0] blk,
			input logic signed [31:0] val);
		merge_word_t w;
		w        = '{default: '0};
		w.req    = req;
		w.blk    = blk;
		w.val    = val;
		pending_reqs.insert(pending_reqs.size(), w);
		items_made++;
	endtask

	task automatic queue_cfg(input logic [3:0] nb);
		merge_word_t w;
		w        = '{default: '0};
		w.is_cfg = 1'b1;
		w.nb     = nb;
		pending_reqs.insert(pending_reqs.size(), w);
	endtask

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 5))
		0: return 32'sh8000_0000;
		1: return 32'sh7fff_ffff;
		2, 3: return $signed($urandom_range(0, 8)) - 4;
		default: return $urandom;
		endcase
	endfunction

	// Mostly sorted runs per block, loaded interleaved, then drained with a few extra pulls
	task automatic merge_round();
		int runs [MAX_BLOCKS][$];
		int total;
		int b;
		total = 0;
		if ($urandom_range(0, 3) != 0)
			queue_req(kwm_pkg::REQ_CLEAR, 3'($urandom), $urandom);
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			repeat ($urandom_range(0, 5))
				runs[i].insert(runs[i].size(), rand_val());
			if ($urandom_range(0, 7) != 0)
				runs[i].sort();
			total += runs[i].size();
		end
		for (int k = total; k > 0; k--) begin
			do
				b = $urandom_range(0, MAX_BLOCKS - 1);
			while (runs[b].size() == 0);
			queue_req(kwm_pkg::REQ_LOAD, 3'(b), runs[b].pop_front());
			if ($urandom_range(0, 7) == 0)
				queue_req(kwm_pkg::REQ_PULL, 3'($urandom), $urandom);
		end
		repeat (total + $urandom_range(0, 2))
			queue_req(kwm_pkg::REQ_PULL, 3'($urandom), $urandom);
	endtask

	task automatic noise_round();
		repeat (10)
			queue_req(2'($urandom_range(0, 3)), 3'($urandom), rand_val());
	endtask

	initial begin
		int         phase;
		int         phase_end;
		int         fill_blk;
		logic [3:0] nb_pick;

		queue_cfg(kwm_pkg::NUM_BLOCKS_RESET);
		queue_req(kwm_pkg::REQ_PULL, 3'd7, 32'sh7fff_ffff);
		queue_req(kwm_pkg::REQ_LOAD, 3'd0, 32'sh8000_0000);
		queue_req(kwm_pkg::REQ_LOAD, 3'd7, 32'sh7fff_ffff);
		queue_req(kwm_pkg::REQ_LOAD, 3'd2, 32'sd42);
		queue_req(kwm_pkg::REQ_LOAD, 3'd5, 32'sd42);
		queue_req(kwm_pkg::REQ_LOAD, 3'd1, 32'sd100);
		queue_req(kwm_pkg::REQ_LOAD, 3'd1, -32'sd7);
		queue_req(REQ_SPARE, 3'd3, 32'sh5a5a_a5a5);
		repeat (7)
			queue_req(kwm_pkg::REQ_PULL, 3'd0, 32'sd0);
		queue_req(kwm_pkg::REQ_LOAD, 3'd6, 32'sd1);
		queue_req(kwm_pkg::REQ_CLEAR, 3'd0, 32'sd0);
		queue_req(kwm_pkg::REQ_PULL, 3'd0, 32'sd0);
		// block 4 sits outside a two-block merge
		queue_cfg(4'd2);
		queue_req(kwm_pkg::REQ_LOAD, 3'd4, 32'sd5);
		queue_req(kwm_pkg::REQ_LOAD, 3'd1, 32'sd9);
		queue_req(kwm_pkg::REQ_PULL, 3'd0, 32'sd0);
		queue_req(kwm_pkg::REQ_PULL, 3'd0, 32'sd0);

		phase = 0;
		while (items_made < ITEM_TARGET) begin
			case (phase)
			0: nb_pick = 4'd0;
			1: nb_pick = 4'd1;
			2: nb_pick = 4'd15;
			3: nb_pick = 4'd8;
			4: nb_pick = 4'd9;
			default: nb_pick = 4'($urandom_range(0, 15));
			endcase
			queue_cfg(nb_pick);
			phase_end = items_made + PHASE_ITEMS;
			if (phase == 6) begin
				// overrun one block to raise the sticky overflow flag
				fill_blk = $urandom_range(0, MAX_BLOCKS - 1);
				queue_req(kwm_pkg::REQ_CLEAR, 3'($urandom), $urandom);
				repeat (BLOCK_DEPTH + 2)
					queue_req(kwm_pkg::REQ_LOAD, 3'(fill_blk), $urandom);
				repeat (6)
					queue_req(kwm_pkg::REQ_PULL, 3'($urandom), $urandom);
			end
			while (items_made < phase_end) begin
				if ($urandom_range(0, 4) == 0)
					noise_round();
				else
					merge_round();
			end
			phase++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || start || cfg_valid || merge_results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (err_cnt == 0 && merge_results_due.size() == 0)
			$display("PASS k_way_merge_sorted_blocks");
		else
			$display("FAIL k_way_merge_sorted_blocks");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL k_way_merge_sorted_blocks");
		$finish;
	end

endmodule
